/* design/fbww_pkg.sv */
package fbww_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OFFSET_W = 17;
  localparam int unsigned COUNT_W  = 2;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_COMMIT = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic {
    CMD_ERASE   = 1'b0,
    CMD_PROGRAM = 1'b1
  } command_t;

  typedef enum logic {
    REG_BASE_ADDRESS = 1'b0,
    REG_MAX_BYTES    = 1'b1
  } reg_index_t;

  localparam logic [OFFSET_W-1:0] MAX_BYTES_RESET = 17'd16384;

endpackage

/* design/flash_byte_to_word_writer.sv */
// A result appears in the output register in the cycle after its request is accepted.
// Throughput: one write or commit request per cycle when out_free; a start request emits
// one erase per page, one per cycle when out_free, and input ready stays low until the last
// erase has been loaded. The single output register sets these rates.
// Reset (rst_n low at a clock edge) clears the packing state, empties the output register,
// and loads base_address with 0 and max_bytes with 16384.
module flash_byte_to_word_writer #(
  parameter int unsigned PAGE_BYTES      = 1024,
  parameter int unsigned PAGES_IN_BUFFER = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [7:0]                    in_data_byte,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_command,
  output logic [fbww_pkg::ADDR_W-1:0]   out_flash_address,
  output logic [fbww_pkg::WORD_W-1:0]   out_word_data,
  output logic                          out_last,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_value
);

  localparam int unsigned IDX_W = (PAGES_IN_BUFFER > 1) ? $clog2(PAGES_IN_BUFFER) : 1;
  localparam logic [IDX_W-1:0] LAST_PAGE = IDX_W'(PAGES_IN_BUFFER - 1);
  localparam logic [fbww_pkg::ADDR_W-1:0] PAGE_STEP = fbww_pkg::ADDR_W'(PAGE_BYTES);

  logic [fbww_pkg::ADDR_W-1:0]   base_r;
  logic [fbww_pkg::OFFSET_W-1:0] max_r;

  logic [fbww_pkg::OFFSET_W-1:0] write_offset_r, write_offset_nxt;
  logic [fbww_pkg::WORD_W-1:0]   pending_word_r, pending_word_nxt;
  logic [fbww_pkg::COUNT_W-1:0]  pending_count_r, pending_count_nxt;

  logic                          erase_busy_r, erase_busy_nxt;
  logic [IDX_W-1:0]              page_idx_r, page_idx_nxt;
  logic [fbww_pkg::ADDR_W-1:0]   erase_addr_r, erase_addr_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          command_r, command_nxt;
  logic [fbww_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [fbww_pkg::WORD_W-1:0]   data_r, data_nxt;
  logic                          last_r, last_nxt;

  logic                          out_free;
  logic                          in_accept;
  logic [fbww_pkg::OFFSET_W:0]   total;
  logic [fbww_pkg::WORD_W-1:0]   filled_word;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !erase_busy_r && out_free;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_command       = command_r;
  assign out_flash_address = addr_r;
  assign out_word_data     = data_r;
  assign out_last          = last_r;

  // Byte count the buffer would hold if this byte were kept.
  assign total = {1'b0, write_offset_r} + (fbww_pkg::OFFSET_W+1)'(pending_count_r)
               + (fbww_pkg::OFFSET_W+1)'(1);

  always_comb begin
    filled_word = pending_word_r;
    filled_word[8*pending_count_r +: 8] = in_data_byte;
  end

  always_comb begin
    write_offset_nxt  = write_offset_r;
    pending_word_nxt  = pending_word_r;
    pending_count_nxt = pending_count_r;
    erase_busy_nxt    = erase_busy_r;
    page_idx_nxt      = page_idx_r;
    erase_addr_nxt    = erase_addr_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    command_nxt       = command_r;
    addr_nxt          = addr_r;
    data_nxt          = data_r;
    last_nxt          = last_r;

    if (erase_busy_r && out_free) begin
      out_valid_nxt  = 1'b1;
      command_nxt    = fbww_pkg::CMD_ERASE;
      addr_nxt       = erase_addr_r;
      data_nxt       = '0;
      last_nxt       = (page_idx_r == LAST_PAGE);
      erase_busy_nxt = (page_idx_r != LAST_PAGE);
      page_idx_nxt   = page_idx_r + IDX_W'(1);
      erase_addr_nxt = erase_addr_r + PAGE_STEP;
    end else if (in_accept) begin
      case (fbww_pkg::action_t'(in_action))
        fbww_pkg::ACT_START: begin
          out_valid_nxt     = 1'b1;
          command_nxt       = fbww_pkg::CMD_ERASE;
          addr_nxt          = base_r;
          data_nxt          = '0;
          last_nxt          = (PAGES_IN_BUFFER == 1);
          erase_busy_nxt    = (PAGES_IN_BUFFER > 1);
          page_idx_nxt      = IDX_W'(1);
          erase_addr_nxt    = base_r + PAGE_STEP;
          write_offset_nxt  = '0;
          pending_word_nxt  = '0;
          pending_count_nxt = '0;
        end
        fbww_pkg::ACT_WRITE: begin
          if (total <= {1'b0, max_r}) begin
            if (pending_count_r == fbww_pkg::COUNT_W'(3)) begin
              out_valid_nxt     = 1'b1;
              command_nxt       = fbww_pkg::CMD_PROGRAM;
              addr_nxt          = base_r + fbww_pkg::ADDR_W'(write_offset_r);
              data_nxt          = filled_word;
              last_nxt          = 1'b1;
              write_offset_nxt  = write_offset_r + fbww_pkg::OFFSET_W'(4);
              pending_word_nxt  = '0;
              pending_count_nxt = '0;
            end else begin
              pending_word_nxt  = filled_word;
              pending_count_nxt = pending_count_r + fbww_pkg::COUNT_W'(1);
            end
          end
        end
        fbww_pkg::ACT_COMMIT: begin
          if (pending_count_r != '0) begin
            out_valid_nxt     = 1'b1;
            command_nxt       = fbww_pkg::CMD_PROGRAM;
            addr_nxt          = base_r + fbww_pkg::ADDR_W'(write_offset_r);
            data_nxt          = pending_word_r;
            last_nxt          = 1'b1;
            write_offset_nxt  = write_offset_r + fbww_pkg::OFFSET_W'(4);
            pending_word_nxt  = '0;
            pending_count_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r          <= '0;
      max_r           <= fbww_pkg::MAX_BYTES_RESET;
      write_offset_r  <= '0;
      pending_word_r  <= '0;
      pending_count_r <= '0;
      erase_busy_r    <= 1'b0;
      page_idx_r      <= '0;
      erase_addr_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (fbww_pkg::reg_index_t'(cfg_index))
          fbww_pkg::REG_BASE_ADDRESS: base_r <= cfg_value;
          fbww_pkg::REG_MAX_BYTES:    max_r  <= cfg_value[fbww_pkg::OFFSET_W-1:0];
          default: begin
          end
        endcase
      end
      write_offset_r  <= write_offset_nxt;
      pending_word_r  <= pending_word_nxt;
      pending_count_r <= pending_count_nxt;
      erase_busy_r    <= erase_busy_nxt;
      page_idx_r      <= page_idx_nxt;
      erase_addr_r    <= erase_addr_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    command_r <= command_nxt;
    addr_r    <= addr_nxt;
    data_r    <= data_nxt;
    last_r    <= last_nxt;
  end

  // An erase burst in progress always has its current erase waiting at the output.
  a_busy_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    erase_busy_r |-> out_valid_r)
    else $error("erase sequencer busy with empty output register");

  // A non-final erase on the output means more erases are still queued.
  a_erase_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && command_r == fbww_pkg::CMD_ERASE && !last_r) |-> erase_busy_r)
    else $error("non-final erase shown with no erase burst pending");

  // A start request restarts the buffer and shows the first erase next cycle.
  a_start_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_action == fbww_pkg::ACT_START) |=>
      (out_valid_r && command_r == fbww_pkg::CMD_ERASE && write_offset_r == '0
       && pending_count_r == '0))
    else $error("start request did not clear state and issue an erase");

endmodule
